FILE: hw/rtl/mck_pkg.sv
// Package for the mecanum chassis kinematics block: types, codes, constants and
// the elaboration-time quarter-sine generator.
// No dependencies.
package mck_pkg;

    typedef longint unsigned t_u64;

    // Stream word widths
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 112;

    // Default angle table depth (full turn), a power of two from 64 to 4096
    localparam int SINE_TABLE_DEPTH_DEF = 256;

    // Datapath widths
    localparam int OPA_W  = 21;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SUM_W  = 20;

    localparam logic [15:0] SCALE_RESET = 16'd1138;

    // Mode codes
    localparam logic [2:0] MODE_ZERO_FORCE = 3'd0;
    localparam logic [2:0] MODE_NO_SPIN    = 3'd1;
    localparam logic [2:0] MODE_SPIN       = 3'd2;
    localparam logic [2:0] MODE_NAV        = 3'd3;

    // Spin gain bands
    localparam logic [2:0] BAND_HIGH = 3'd0;
    localparam logic [2:0] BAND_MID  = 3'd1;
    localparam logic [2:0] BAND_LOW  = 3'd2;
    localparam logic [2:0] BAND_MIN  = 3'd3;
    localparam logic [2:0] BAND_ZERO = 3'd4;

    localparam logic [11:0] VOLT_HIGH_LO = 12'd1800;
    localparam logic [11:0] VOLT_HIGH_HI = 12'd2400;
    localparam logic [11:0] VOLT_MID_LO  = 12'd1400;
    localparam logic [11:0] VOLT_LOW_LO  = 12'd1200;

    localparam t_u64 HALF_PI_Q30 = 64'd1686629713;
    localparam t_u64 Q15_ONE     = 64'd32767;
    localparam t_u64 Q30_HALF    = 64'd536870912;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_CVX0,
        ST_CVX1,
        ST_CVY0,
        ST_CVY1,
        ST_MX,
        ST_MY,
        ST_BVX0,
        ST_BVX1,
        ST_BVY0,
        ST_BVY1,
        ST_SPIN,
        ST_MIX
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_NEG
    } t_acc_op;

    function automatic logic [2:0] band_of_voltage(input logic [11:0] volt);
        logic [2:0] band;
        if (volt >= VOLT_HIGH_LO && volt <= VOLT_HIGH_HI) begin
            band = BAND_HIGH;
        end else if (volt >= VOLT_MID_LO && volt < VOLT_HIGH_LO) begin
            band = BAND_MID;
        end else if (volt >= VOLT_LOW_LO && volt < VOLT_MID_LO) begin
            band = BAND_LOW;
        end else begin
            band = BAND_MIN;
        end
        return band;
    endfunction

    // Spin in units of 10000 times the gain
    function automatic logic [14:0] spin_unit_of_band(input logic [2:0] band);
        logic [14:0] unit;
        case (band)
            BAND_HIGH: unit = 15'd18000;
            BAND_MID:  unit = 15'd15000;
            BAND_LOW:  unit = 15'd10000;
            BAND_MIN:  unit = 15'd5000;
            default:   unit = 15'd0;
        endcase
        return unit;
    endfunction

    // Three times the spin unit over one hundred, exact for every band
    function automatic logic [9:0] nav_factor_of_band(input logic [2:0] band);
        logic [9:0] fac;
        case (band)
            BAND_HIGH: fac = 10'd540;
            BAND_MID:  fac = 10'd450;
            BAND_LOW:  fac = 10'd300;
            BAND_MIN:  fac = 10'd150;
            default:   fac = 10'd0;
        endcase
        return fac;
    endfunction

    // Quarter-wave sine in Q15 from an angle in Q2.30 radians (Taylor series)
    function automatic logic [14:0] quarter_sine_q15(input t_u64 x);
        t_u64   x2;
        t_u64   term;
        t_u64   v;
        longint sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (t_u64'(sum) * Q15_ONE + Q30_HALF) >> 30;
        if (v > Q15_ONE) begin
            v = Q15_ONE;
        end
        return v[14:0];
    endfunction

endpackage

FILE: hw/rtl/mecanum_chassis_kinematics_top.sv
// Mecanum chassis kinematics: wheel reference mixing and body velocity estimate,
// worked through one shared multiply-accumulate unit under a state sequencer.
// Depends on mck_pkg.
//
// Usage
//   One input word per control tick arrives on s_axis; one result word per tick
//   leaves on m_axis. The wheel speed scale is written through i_cfg_we and
//   i_cfg_wdata; the user must write it only while the block is idle, which the block itself does not enforce.
//   Each item is worked in order through the single 21 x 17 bit multiplier: a
//   sine/cosine lookup, the products of the rotated command, the scaled wheel
//   sums and the body velocity, the navigation spin product and the mix step.
//   A new item is accepted only once the previous one has left the mix step.
//   s_axis_tready is high only while the sequencer is idle.
//   The result sits in an output register. The next word may be accepted while
//   it waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds in its mix step until the register frees.
//   Reset clears the sequencer and the output valid, loads the scale with its
//   default and sets the spin gain band to zero gain. A tick's capacitor voltage
//   sets the spin gain used by the following tick.
//   SINE_TABLE_DEPTH must be a power of two.
module mecanum_chassis_kinematics_top
    import mck_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mode[2:0], cmd_vx[18:3], cmd_vy[34:19], cmd_spin[51:35],
    // nav_spin_percent[58:52], heading_offset[74:59], cap_voltage[86:75],
    // speed_front_left[104:87], speed_front_right[122:105],
    // speed_back_left[140:123], speed_back_right[158:141], zero[159]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // ref_front_left[17:0], ref_front_right[35:18], ref_back_left[53:36],
    // ref_back_right[71:54], motors_enabled[72], body_vx[88:73],
    // body_vy[104:89], zero[111:105]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int L   = $clog2(SINE_TABLE_DEPTH);
    localparam int QW  = L - 2;
    localparam int Q   = SINE_TABLE_DEPTH / 4;
    localparam int TIW = L - 1;

    localparam logic signed [ACC_W-1:0] RND15 = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);

    // Quarter-wave table, entry j holds the sine of j steps of the full table
    logic [14:0] w_qsin [Q+1];

    for (genvar g = 0; g <= Q; g++) begin : g_qsin
        localparam t_u64 X_Q30 = (t_u64'(4 * g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        assign w_qsin[g] = quarter_sine_q15(X_Q30);
    end

    function automatic logic signed [17:0] sat18(input logic signed [SUM_W-1:0] v);
        logic signed [17:0] r;
        if (v > SUM_W'(131071)) begin
            r = 18'sd131071;
        end else if (v < -SUM_W'(131072)) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sd32767;
        end else if (v < -24'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Input word fields
    logic [2:0]         w_mode;
    logic signed [15:0] w_vx;
    logic signed [15:0] w_vy;
    logic signed [16:0] w_cmd_spin;
    logic [6:0]         w_pct;
    logic [15:0]        w_angle;
    logic [11:0]        w_volt;
    logic signed [17:0] w_fl;
    logic signed [17:0] w_fr;
    logic signed [17:0] w_bl;
    logic signed [17:0] w_br;

    assign w_mode     = s_axis_tdata[2:0];
    assign w_vx       = s_axis_tdata[18:3];
    assign w_vy       = s_axis_tdata[34:19];
    assign w_cmd_spin = s_axis_tdata[51:35];
    assign w_pct      = s_axis_tdata[58:52];
    assign w_angle    = s_axis_tdata[74:59];
    assign w_volt     = s_axis_tdata[86:75];
    assign w_fl       = s_axis_tdata[104:87];
    assign w_fr       = s_axis_tdata[122:105];
    assign w_bl       = s_axis_tdata[140:123];
    assign w_br       = s_axis_tdata[158:141];

    logic signed [SUM_W-1:0] w_fl_x;
    logic signed [SUM_W-1:0] w_fr_x;
    logic signed [SUM_W-1:0] w_bl_x;
    logic signed [SUM_W-1:0] w_br_x;
    logic signed [SUM_W-1:0] w_sumx;
    logic signed [SUM_W-1:0] w_sumy;

    assign w_fl_x = {{(SUM_W-18){w_fl[17]}}, w_fl};
    assign w_fr_x = {{(SUM_W-18){w_fr[17]}}, w_fr};
    assign w_bl_x = {{(SUM_W-18){w_bl[17]}}, w_bl};
    assign w_br_x = {{(SUM_W-18){w_br[17]}}, w_br};
    assign w_sumx = w_fl_x + w_bl_x - w_br_x - w_fr_x;
    assign w_sumy = w_bl_x + w_br_x - w_fl_x - w_fr_x;

    // Control state
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    logic [2:0]  r_band;
    logic [15:0] r_scale;

    // Captured operands
    logic [2:0]              r_mode;
    logic signed [15:0]      r_vx;
    logic signed [15:0]      r_vy;
    logic signed [16:0]      r_cmd_spin;
    logic [6:0]              r_pct;
    logic [1:0]              r_quad;
    logic [QW-1:0]           r_j;
    logic signed [SUM_W-1:0] r_sumx;
    logic signed [SUM_W-1:0] r_sumy;
    logic [14:0]             r_unit;
    logic [9:0]              r_nav_fac;

    // Intermediate results
    logic signed [15:0]      r_sin;
    logic signed [15:0]      r_cos;
    logic signed [17:0]      r_cvx;
    logic signed [17:0]      r_cvy;
    logic signed [OPA_W-1:0] r_mx;
    logic signed [OPA_W-1:0] r_my;
    logic signed [15:0]      r_bvx;
    logic signed [15:0]      r_bvy;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    // Sequencer outputs
    t_acc_op                 acc_op;
    logic signed [OPA_W-1:0] opa;
    logic signed [OPB_W-1:0] opb;
    logic                    out_load;
    logic                    accept;

    // Shared multiply-accumulate unit
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_x;

    assign w_prod   = opa * opb;
    assign w_prod_x = {w_prod[PROD_W-1], w_prod};

    always_comb begin
        case (acc_op)
            ACC_LOAD: n_acc = w_prod_x;
            ACC_ADD:  n_acc = r_acc + w_prod_x;
            ACC_SUB:  n_acc = r_acc - w_prod_x;
            ACC_NEG:  n_acc = -w_prod_x;
            default:  n_acc = r_acc;
        endcase
    end

    // Rounded views of the accumulator
    logic signed [ACC_W-1:0] w_acc_r15;
    logic signed [ACC_W-1:0] w_acc_r16;
    logic signed [23:0]      w_q15;
    logic signed [22:0]      w_q16;

    assign w_acc_r15 = r_acc + RND15;
    assign w_acc_r16 = r_acc + RND16;
    assign w_q15     = w_acc_r15[ACC_W-1:15];
    assign w_q16     = w_acc_r16[ACC_W-1:16];

    // Sine and cosine from the quarter-wave table
    logic [TIW-1:0]     w_b_idx;
    logic signed [15:0] w_a16;
    logic signed [15:0] w_b16;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    assign w_b_idx = TIW'(Q) - {1'b0, r_j};
    assign w_a16   = {1'b0, w_qsin[{1'b0, r_j}]};
    assign w_b16   = {1'b0, w_qsin[w_b_idx]};

    always_comb begin
        case (r_quad)
            2'd0: begin
                w_sin = w_a16;
                w_cos = w_b16;
            end
            2'd1: begin
                w_sin = w_b16;
                w_cos = -w_a16;
            end
            2'd2: begin
                w_sin = -w_a16;
                w_cos = -w_b16;
            end
            default: begin
                w_sin = -w_b16;
                w_cos = w_a16;
            end
        endcase
    end

    // Operand extensions
    logic signed [OPA_W-1:0] w_vx_a;
    logic signed [OPA_W-1:0] w_vy_a;
    logic signed [OPA_W-1:0] w_sumx_a;
    logic signed [OPA_W-1:0] w_sumy_a;
    logic signed [OPA_W-1:0] w_pct_a;
    logic signed [OPB_W-1:0] w_sin_b;
    logic signed [OPB_W-1:0] w_cos_b;
    logic signed [OPB_W-1:0] w_scale_b;
    logic signed [OPB_W-1:0] w_fac_b;

    assign w_vx_a    = {{(OPA_W-16){r_vx[15]}}, r_vx};
    assign w_vy_a    = {{(OPA_W-16){r_vy[15]}}, r_vy};
    assign w_sumx_a  = {{(OPA_W-SUM_W){r_sumx[SUM_W-1]}}, r_sumx};
    assign w_sumy_a  = {{(OPA_W-SUM_W){r_sumy[SUM_W-1]}}, r_sumy};
    assign w_pct_a   = {{(OPA_W-7){1'b0}}, r_pct};
    assign w_sin_b   = {{(OPB_W-16){r_sin[15]}}, r_sin};
    assign w_cos_b   = {{(OPB_W-16){r_cos[15]}}, r_cos};
    assign w_scale_b = {{(OPB_W-16){1'b0}}, r_scale};
    assign w_fac_b   = {{(OPB_W-10){1'b0}}, r_nav_fac};

    // Sequencer: next state and control
    always_comb begin
        n_state  = r_state;
        acc_op   = ACC_HOLD;
        opa      = w_vx_a;
        opb      = w_cos_b;
        out_load = 1'b0;
        accept   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG: n_state = ST_CVX0;
            ST_CVX0: begin
                acc_op  = ACC_LOAD;
                n_state = ST_CVX1;
            end
            ST_CVX1: begin
                acc_op  = ACC_SUB;
                opa     = w_vy_a;
                opb     = w_sin_b;
                n_state = ST_CVY0;
            end
            ST_CVY0: begin
                acc_op  = ACC_LOAD;
                opb     = w_sin_b;
                n_state = ST_CVY1;
            end
            ST_CVY1: begin
                acc_op  = ACC_ADD;
                opa     = w_vy_a;
                n_state = ST_MX;
            end
            ST_MX: begin
                acc_op  = ACC_LOAD;
                opa     = w_sumx_a;
                opb     = w_scale_b;
                n_state = ST_MY;
            end
            ST_MY: begin
                acc_op  = ACC_LOAD;
                opa     = w_sumy_a;
                opb     = w_scale_b;
                n_state = ST_BVX0;
            end
            ST_BVX0: begin
                acc_op  = ACC_LOAD;
                opa     = r_mx;
                n_state = ST_BVX1;
            end
            ST_BVX1: begin
                acc_op  = ACC_ADD;
                opa     = r_my;
                opb     = w_sin_b;
                n_state = ST_BVY0;
            end
            ST_BVY0: begin
                acc_op  = ACC_NEG;
                opa     = r_mx;
                opb     = w_sin_b;
                n_state = ST_BVY1;
            end
            ST_BVY1: begin
                acc_op  = ACC_ADD;
                opa     = r_my;
                n_state = ST_SPIN;
            end
            ST_SPIN: begin
                acc_op  = ACC_LOAD;
                opa     = w_pct_a;
                opb     = w_fac_b;
                n_state = ST_MIX;
            end
            ST_MIX: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    // Wheel mix
    logic signed [SUM_W-1:0] w_spin;
    logic signed [SUM_W-1:0] w_cvx_x;
    logic signed [SUM_W-1:0] w_cvy_x;
    logic signed [SUM_W-1:0] w_diff;
    logic signed [SUM_W-1:0] w_plus;
    logic signed [17:0]      w_ref_fl;
    logic signed [17:0]      w_ref_fr;
    logic signed [17:0]      w_ref_bl;
    logic signed [17:0]      w_ref_br;
    logic                    w_enabled;

    always_comb begin
        case (r_mode)
            MODE_NO_SPIN: w_spin = '0;
            MODE_SPIN:    w_spin = {{(SUM_W-15){1'b0}}, r_unit};
            MODE_NAV:     w_spin = r_acc[SUM_W-1:0];
            default:      w_spin = {{(SUM_W-17){r_cmd_spin[16]}}, r_cmd_spin};
        endcase
    end

    assign w_cvx_x   = {{(SUM_W-18){r_cvx[17]}}, r_cvx};
    assign w_cvy_x   = {{(SUM_W-18){r_cvy[17]}}, r_cvy};
    assign w_diff    = w_cvx_x - w_cvy_x;
    assign w_plus    = w_cvx_x + w_cvy_x;
    assign w_ref_fl  = sat18(w_diff - w_spin);
    assign w_ref_fr  = sat18(w_plus + w_spin);
    assign w_ref_bl  = sat18(w_plus - w_spin);
    assign w_ref_br  = sat18(w_diff + w_spin);
    assign w_enabled = (r_mode != MODE_ZERO_FORCE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_band      <= BAND_ZERO;
            r_scale     <= SCALE_RESET;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // band takes effect on the next tick
            if (accept) begin
                r_band <= band_of_voltage(w_volt);
            end
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (accept) begin
            r_mode     <= w_mode;
            r_vx       <= w_vx;
            r_vy       <= w_vy;
            r_cmd_spin <= w_cmd_spin;
            r_pct      <= w_pct;
            r_quad     <= w_angle[15:14];
            r_j        <= w_angle[13 -: QW];
            r_sumx     <= w_sumx;
            r_sumy     <= w_sumy;
            r_unit     <= spin_unit_of_band(r_band);
            r_nav_fac  <= nav_factor_of_band(r_band);
        end
        case (r_state)
            ST_TRIG: begin
                r_sin <= w_sin;
                r_cos <= w_cos;
            end
            ST_CVY0: r_cvx <= w_q15[17:0];
            ST_MX:   r_cvy <= w_q15[17:0];
            ST_MY:   r_mx  <= w_q16[OPA_W-1:0];
            ST_BVX0: r_my  <= w_q16[OPA_W-1:0];
            ST_BVY0: r_bvx <= sat16(w_q15);
            ST_SPIN: r_bvy <= sat16(w_q15);
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= {7'b0, r_bvy, r_bvx, w_enabled,
                           w_ref_br, w_ref_bl, w_ref_fr, w_ref_fl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: tb/mck_kinematics_checker.sv
// Checker for the mecanum chassis kinematics block: watches the input, output and
// configuration ports, predicts each result word and compares it field by field.
// Depends on mck_pkg.
module mck_kinematics_checker
    import mck_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               pad;
        logic signed [17:0] spd_br;
        logic signed [17:0] spd_bl;
        logic signed [17:0] spd_fr;
        logic signed [17:0] spd_fl;
        logic [11:0]        volt;
        logic [15:0]        angle;
        logic [6:0]         nav_pct;
        logic signed [16:0] spin_cmd;
        logic signed [15:0] cmd_vy;
        logic signed [15:0] cmd_vx;
        logic [2:0]         mode;
    } t_tick_in;

    typedef struct packed {
        logic [6:0]         pad;
        logic signed [15:0] body_vy;
        logic signed [15:0] body_vx;
        logic               motors_en;
        logic signed [17:0] ref_br;
        logic signed [17:0] ref_bl;
        logic signed [17:0] ref_fr;
        logic signed [17:0] ref_fl;
    } t_chassis_out;

    t_chassis_out chassis_due[$];
    logic [15:0]  speed_scale;
    logic [2:0]   gain_band;

    // floor((v + 2^(sh-1)) / 2^sh)
    function automatic longint round_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_bits(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Q15 sine of r steps of one SINE_TABLE_DEPTH-th of a quarter turn, Taylor series carried in Q2.30
    function automatic longint quarter_wave(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        x    = (longint'(r) * HALF_PI_Q30) / longint'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (longint'(acc) * Q15_ONE + Q30_HALF) >> 30;
        if (v > Q15_ONE) begin
            v = Q15_ONE;
        end
        return longint'(v);
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] ang, output longint s,
                                          output longint c);
        int unsigned k;
        int unsigned q;
        int unsigned r;
        longint      a;
        longint      b;
        k = (int'(ang) * SINE_TABLE_DEPTH) >> 16;
        q = (4 * k) / SINE_TABLE_DEPTH;
        r = 4 * k - q * SINE_TABLE_DEPTH;
        a = quarter_wave(r);
        b = quarter_wave(SINE_TABLE_DEPTH - r);
        case (q % 4)
            0:       begin s = a;  c = b;  end
            1:       begin s = b;  c = -a; end
            2:       begin s = -a; c = -b; end
            default: begin s = -b; c = a;  end
        endcase
    endfunction

    // Work out one tick and advance the stored gain band
    function automatic t_chassis_out solve_chassis(input t_tick_in t);
        t_chassis_out e;
        longint       unit;
        longint       spin;
        longint       s;
        longint       c;
        longint       cvx;
        longint       cvy;
        longint       mx;
        longint       my;
        longint       k;
        case (gain_band)
            BAND_HIGH: unit = 18000;
            BAND_MID:  unit = 15000;
            BAND_LOW:  unit = 10000;
            BAND_MIN:  unit = 5000;
            default:   unit = 0;
        endcase
        case (t.mode)
            MODE_NO_SPIN: spin = 0;
            MODE_SPIN:    spin = unit;
            MODE_NAV:     spin = (3 * unit * longint'(t.nav_pct)) / 100;
            default:      spin = longint'(t.spin_cmd);
        endcase
        angle_sin_cos(t.angle, s, c);
        cvx = round_q(longint'(t.cmd_vx) * c - longint'(t.cmd_vy) * s, 15);
        cvy = round_q(longint'(t.cmd_vx) * s + longint'(t.cmd_vy) * c, 15);
        e           = '0;
        e.ref_fl    = 18'(clamp_bits(cvx - cvy - spin, 18));
        e.ref_fr    = 18'(clamp_bits(cvx + cvy + spin, 18));
        e.ref_bl    = 18'(clamp_bits(cvx + cvy - spin, 18));
        e.ref_br    = 18'(clamp_bits(cvx - cvy + spin, 18));
        e.motors_en = (t.mode != MODE_ZERO_FORCE);
        k  = longint'(speed_scale);
        mx = round_q((longint'(t.spd_fl) + t.spd_bl - t.spd_br - t.spd_fr) * k, 16);
        my = round_q((-longint'(t.spd_fl) + t.spd_bl + t.spd_br - t.spd_fr) * k, 16);
        e.body_vx = 16'(clamp_bits(round_q(mx * c + my * s, 15), 16));
        e.body_vy = 16'(clamp_bits(round_q(-mx * s + my * c, 15), 16));
        if (t.volt >= VOLT_HIGH_LO && t.volt <= VOLT_HIGH_HI) begin
            gain_band = BAND_HIGH;
        end else if (t.volt >= VOLT_MID_LO && t.volt < VOLT_HIGH_LO) begin
            gain_band = BAND_MID;
        end else if (t.volt >= VOLT_LOW_LO && t.volt < VOLT_MID_LO) begin
            gain_band = BAND_LOW;
        end else begin
            gain_band = BAND_MIN;
        end
        return e;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("%0t mck_kinematics_checker: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic match_field(input string name, input longint got, input longint want);
        if (got != want) begin
            note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_chassis_out got;
        t_chassis_out want;
        if (!i_rst_n) begin
            chassis_due.delete();
            speed_scale   = SCALE_RESET;
            gain_band     = BAND_ZERO;
            o_outstanding = 0;
        end else begin
            if (i_cfg_we) begin
                speed_scale = i_cfg_wdata;
            end
            // compare before queueing: a word leaving now never belongs to one entering now
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (chassis_due.size() == 0) begin
                    note_mismatch($sformatf("result word %h with nothing expected", got));
                end else begin
                    want = chassis_due.pop_front();
                    match_field("ref_front_left", got.ref_fl, want.ref_fl);
                    match_field("ref_front_right", got.ref_fr, want.ref_fr);
                    match_field("ref_back_left", got.ref_bl, want.ref_bl);
                    match_field("ref_back_right", got.ref_br, want.ref_br);
                    match_field("motors_enabled", got.motors_en, want.motors_en);
                    match_field("body_vx", got.body_vx, want.body_vx);
                    match_field("body_vy", got.body_vy, want.body_vy);
                    match_field("pad bits", got.pad, want.pad);
                end
            end
            if (i_in_valid && i_in_ready) begin
                chassis_due.push_back(solve_chassis(t_tick_in'(i_in_data)));
            end
            o_outstanding = chassis_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Top of the mecanum chassis kinematics testbench: clock, reset, tick stimulus,
// receiver back-pressure and the verdict. Depends on mck_pkg, the block and
// mck_kinematics_checker.
module tb_top;
    import mck_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = SINE_TABLE_DEPTH_DEF;
    localparam int PHASE_TICKS    = 150;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT     = 3000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic [2:0] MODE_OTHER  = 3'd4;
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [15:0]            i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int   mismatches;
    int   outstanding;
    int   burst_left;
    logic rx_hold_req;

    mecanum_chassis_kinematics_top #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mck_kinematics_checker #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH)
    ) u_chassis_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one tick word; bursts of words are separated by random gaps
    task automatic offer_tick(input logic [2:0] mode, input logic [15:0] vx,
                              input logic [15:0] vy, input logic [16:0] spin,
                              input logic [6:0] pct, input logic [15:0] ang,
                              input logic [11:0] volt, input logic [17:0] fl,
                              input logic [17:0] fr, input logic [17:0] bl,
                              input logic [17:0] br);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, br, bl, fr, fl, volt, ang, pct, spin, vy, vx, mode};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Full-range values, more often the extremes or near zero
    function automatic logic [31:0] edgy(input int w);
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = (32'd1 << (w - 1)) - 1;
            1:       v = 32'd1 << (w - 1);
            2:       v = '1;
            3:       v = '0;
            4:       v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300)
                                                     : -$urandom_range(0, 300);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic offer_random_tick();
        logic [2:0]  mode;
        logic [6:0]  pct;
        logic [15:0] ang;
        logic [11:0] volt;
        logic [11:0] volt_edges[8];
        volt_edges = '{VOLT_LOW_LO - 1, VOLT_LOW_LO, VOLT_MID_LO - 1, VOLT_MID_LO,
                       VOLT_HIGH_LO - 1, VOLT_HIGH_LO, VOLT_HIGH_HI, VOLT_HIGH_HI + 1};
        if ($urandom_range(0, 7) == 0) begin
            mode = 3'($urandom_range(MODE_SPARE5, MODE_SPARE7));
        end else begin
            mode = 3'($urandom_range(MODE_ZERO_FORCE, MODE_OTHER));
        end
        pct  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                           : 7'($urandom_range(0, 100));
        volt = ($urandom_range(0, 2) == 0) ? volt_edges[$urandom_range(0, 7)]
                                           : 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) begin
            ang = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        end else begin
            ang = 16'($urandom);
        end
        offer_tick(mode, 16'(edgy(16)), 16'(edgy(16)), 17'(edgy(17)), pct, ang, volt,
                   18'(edgy(18)), 18'(edgy(18)), 18'(edgy(18)), 18'(edgy(18)));
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: stall pattern that changes duty now and then, plus one long hold-off
    initial begin
        int duty;
        int span;
        m_axis_tready = 1'b0;
        duty = 100;
        span = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (span == 0) begin
                    span = $urandom_range(20, 200);
                    case ($urandom_range(0, 4))
                        0:       duty = 100;
                        1:       duty = 90;
                        2:       duty = 60;
                        3:       duty = 30;
                        default: duty = 5;
                    endcase
                end
                span--;
                m_axis_tready <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        logic [15:0] scales[5];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rx_hold_req   = 1'b0;
        burst_left    = 0;
        scales        = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'($urandom)};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Spin gain chain through every voltage band, starting from the zero-gain reset band
        offer_tick(MODE_SPIN, 1000, 0, 0, 0, 0, 2000, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 0, 1000, 0, 0, 0, 1500, 500, -500, 500, -500);
        offer_tick(MODE_NAV, -700, 300, 0, 100, 4096, 1300, 1000, 2000, 3000, 4000);
        offer_tick(MODE_NAV, 2000, -2000, 0, 127, 12288, 1000, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 100, 100, 0, 0, 20000, 1799, -300, 300, 0, 0);
        offer_tick(MODE_NAV, 0, 0, 0, 0, 0, 1800, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 0, 0, 0, 0, 0, 2400, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 0, 0, 0, 0, 0, 2401, 0, 0, 0, 0);
        offer_tick(MODE_NAV, 5, 5, 0, 33, 100, 1400, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 0, 0, 0, 0, 0, 1399, 0, 0, 0, 0);
        offer_tick(MODE_SPIN, 0, 0, 0, 0, 0, 1200, 0, 0, 0, 0);
        // Zero force still drives references; field extremes and full-scale body speed
        offer_tick(MODE_ZERO_FORCE, 32767, -32768, -65536, 127, 0, 4095,
                   131071, 131071, 131071, 131071);
        offer_tick(MODE_ZERO_FORCE, -32768, 32767, 65535, 0, 32768, 0,
                   131071, -131072, 131071, -131072);
        offer_tick(MODE_NO_SPIN, -32768, -32768, 65535, 100, 16384, 1199,
                   -131072, 131071, -131072, 131071);
        offer_tick(MODE_OTHER, 12345, -54, 65535, 0, 49152, 2000, 0, 0, 0, 0);
        offer_tick(MODE_SPARE5, 32767, 32767, -1, 0, 65535, 2000, 1, 2, 3, 4);
        offer_tick(MODE_SPARE6, -1, 1, 1, 0, 255, 2000, -1, -1, -1, -1);
        offer_tick(MODE_SPARE7, 32767, 32767, -65536, 0, 256, 2000, 0, 0, 131071, 0);
        offer_tick(MODE_NAV, 32767, 32767, 0, 100, 8192, 1199, 90000, -90000, 0, 0);
        offer_tick(MODE_SPIN, -32768, 32767, 0, 0, 24576, 2000, 0, 0, 0, 0);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_scale(scales[ph]);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                // hold the receiver off mid-phase so the block backs up onto its input
                if (ph == 1 && i == 40) begin
                    rx_hold_req = 1'b1;
                end
                offer_random_tick();
            end
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mck_pkg.sv
hw/rtl/mecanum_chassis_kinematics_top.sv
tb/mck_kinematics_checker.sv
tb/tb_top.sv
